// ----- design/tprm_pkg.sv -----
package tprm_pkg;

	localparam int NOW_W        = 48;
	localparam int BYTES_W      = 47;
	localparam int DONE_W       = 48;
	localparam int RATE_W       = 49;
	localparam int PCT_W        = 7;
	localparam int ETA_W        = 48;
	localparam int TOTAL_W      = 48;
	localparam int WIN_W        = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 48;
	localparam int DIV_W        = 58;
	localparam int DIVISOR_W    = 49;
	localparam int DIV_CNT_W    = 6;
	localparam int DIV_STEPS    = DIV_W;
	localparam int IN_TDATA_W   = 144;
	localparam int OUT_TDATA_W  = 160;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW = 1'b1;

	localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd500;
	localparam logic [WIN_W-1:0]  WINDOW_MIN   = 16'd1;
	localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
	localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

	typedef enum logic [4:0] {
		S_IDLE,
		S_SUM,
		S_CHECK,
		S_DELTA,
		S_RMUL1,
		S_RMUL2,
		S_RDIV_GO,
		S_RDIV,
		S_PCT,
		S_PMUL1,
		S_PMUL2,
		S_PDIV_GO,
		S_PDIV,
		S_ETA,
		S_EDIV_GO,
		S_EDIV,
		S_OUT
	} state_t;

endpackage

// ----- design/tprm_div.sv -----
module tprm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tprm_pkg::DIV_W-1:0]     dividend,
	input  logic [tprm_pkg::DIVISOR_W-1:0] divisor,
	output logic                           busy,
	output logic                           done,
	output logic [tprm_pkg::DIV_W-1:0]     quotient
);

	logic [tprm_pkg::DIV_W-1:0]     quo_q;
	logic [tprm_pkg::DIVISOR_W-1:0] rem_q;
	logic [tprm_pkg::DIVISOR_W-1:0] dvs_q;
	logic [tprm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [tprm_pkg::DIVISOR_W:0]   rem_sh;
	logic [tprm_pkg::DIVISOR_W+1:0] diff;
	logic                           qbit;
	logic [tprm_pkg::DIVISOR_W-1:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, quo_q[tprm_pkg::DIV_W-1]};
		diff     = {1'b0, rem_sh} - {2'b00, dvs_q};
		qbit     = ~diff[tprm_pkg::DIVISOR_W+1];
		rem_next = qbit ? diff[tprm_pkg::DIVISOR_W-1:0] : rem_sh[tprm_pkg::DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= tprm_pkg::DIV_CNT_W'(tprm_pkg::DIV_STEPS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[tprm_pkg::DIV_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign busy     = run_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/transfer_progress_rate_monitor.sv -----
// Progress report monitor. One report enters on s_* and one result leaves on m_*. The first
// report after reset (or any report while the recorded tick is zero) records time and done
// bytes without updating the rate; later reports refresh the rate once the window has passed.
// A new report is taken only after the previous one has run through all of its states. The
// result is set by up to three passes through one shared restoring divider that retires one
// quotient bit per cycle over 58 bits, each pass ending with the pickup of the quotient (rate
// update, percent below total, ETA with a known rate). A finished result waits in the output
// register while the next report is taken; a new result is held back only while the previous
// one is still untaken. Configuration writes take effect at once and are meant for idle periods.
module transfer_progress_rate_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// now_ms[47:0], base_bytes[94:48], transferred_bytes[141:95], cancel_flag[142], zero[143]
	input  logic [tprm_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// done_bytes[47:0], rate_bytes_per_sec[96:48], percent_done[103:97],
	// eta_seconds[151:104], cancel_request[152], zero[159:153]
	output logic [tprm_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_we,
	input  logic [tprm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tprm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	tprm_pkg::state_t state_q, state_d;

	logic [tprm_pkg::TOTAL_W-1:0]  total_q;
	logic [tprm_pkg::WIN_W-1:0]    window_q;
	logic [tprm_pkg::NOW_W-1:0]    last_tick_q;
	logic [tprm_pkg::DONE_W-1:0]   last_bytes_q;
	logic [tprm_pkg::RATE_W-1:0]   rate_q;

	logic [tprm_pkg::NOW_W-1:0]    now_q;
	logic [tprm_pkg::BYTES_W-1:0]  base_q;
	logic [tprm_pkg::BYTES_W-1:0]  moved_q;
	logic                          cancel_q;
	logic [tprm_pkg::DONE_W-1:0]   done_q;
	logic [tprm_pkg::NOW_W-1:0]    elapsed_q;
	logic [tprm_pkg::DONE_W-1:0]   opnd_q;
	logic [tprm_pkg::DIV_W-1:0]    prod_q;
	logic [tprm_pkg::PCT_W-1:0]    pct_q;
	logic [tprm_pkg::ETA_W-1:0]    eta_q;

	logic                          m_tvalid_q;
	logic [tprm_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [tprm_pkg::WIN_W-1:0]      win_eff;
	logic [tprm_pkg::DIV_W-1:0]      opnd_ext;
	logic [tprm_pkg::DONE_W:0]       delta_diff;
	logic                            out_free;
	logic                            div_start;
	logic [tprm_pkg::DIVISOR_W-1:0]  div_divisor;
	logic                            div_busy;
	logic                            div_done;
	logic [tprm_pkg::DIV_W-1:0]      div_quo;

	assign win_eff    = (window_q == '0) ? tprm_pkg::WINDOW_MIN : window_q;
	assign opnd_ext   = {{(tprm_pkg::DIV_W - tprm_pkg::DONE_W){1'b0}}, opnd_q};
	assign delta_diff = {1'b0, done_q} - {1'b0, last_bytes_q};
	assign out_free   = !m_tvalid_q || m_tready;

	tprm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tprm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		div_start   = 1'b0;
		div_divisor = {1'b0, elapsed_q};
		unique case (state_q)
			tprm_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = tprm_pkg::S_SUM;
				end
			end
			tprm_pkg::S_SUM: state_d = tprm_pkg::S_CHECK;
			tprm_pkg::S_CHECK: begin
				priority if (last_tick_q == '0) begin
					state_d = tprm_pkg::S_PCT;
				end else if (elapsed_q >= {{(tprm_pkg::NOW_W - tprm_pkg::WIN_W){1'b0}}, win_eff}) begin
					state_d = tprm_pkg::S_DELTA;
				end else begin
					state_d = tprm_pkg::S_PCT;
				end
			end
			tprm_pkg::S_DELTA: state_d = tprm_pkg::S_RMUL1;
			tprm_pkg::S_RMUL1: state_d = tprm_pkg::S_RMUL2;
			tprm_pkg::S_RMUL2: state_d = tprm_pkg::S_RDIV_GO;
			tprm_pkg::S_RDIV_GO: begin
				div_start   = 1'b1;
				div_divisor = {1'b0, elapsed_q};
				state_d     = tprm_pkg::S_RDIV;
			end
			tprm_pkg::S_RDIV: begin
				if (div_done) begin
					state_d = tprm_pkg::S_PCT;
				end
			end
			tprm_pkg::S_PCT: begin
				if (total_q != '0 && done_q < total_q) begin
					state_d = tprm_pkg::S_PMUL1;
				end else begin
					state_d = tprm_pkg::S_ETA;
				end
			end
			tprm_pkg::S_PMUL1: state_d = tprm_pkg::S_PMUL2;
			tprm_pkg::S_PMUL2: state_d = tprm_pkg::S_PDIV_GO;
			tprm_pkg::S_PDIV_GO: begin
				div_start   = 1'b1;
				div_divisor = {1'b0, total_q};
				state_d     = tprm_pkg::S_PDIV;
			end
			tprm_pkg::S_PDIV: begin
				if (div_done) begin
					state_d = tprm_pkg::S_ETA;
				end
			end
			tprm_pkg::S_ETA: begin
				if (rate_q != '0 && total_q > done_q) begin
					state_d = tprm_pkg::S_EDIV_GO;
				end else begin
					state_d = tprm_pkg::S_OUT;
				end
			end
			tprm_pkg::S_EDIV_GO: begin
				div_start   = 1'b1;
				div_divisor = rate_q;
				state_d     = tprm_pkg::S_EDIV;
			end
			tprm_pkg::S_EDIV: begin
				if (div_done) begin
					state_d = tprm_pkg::S_OUT;
				end
			end
			tprm_pkg::S_OUT: begin
				if (out_free) begin
					state_d = tprm_pkg::S_IDLE;
				end
			end
			default: state_d = tprm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			window_q     <= tprm_pkg::WINDOW_RESET;
			last_tick_q  <= '0;
			last_bytes_q <= '0;
			rate_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tprm_pkg::REG_TOTAL_BYTES: total_q <= cfg_data;
					tprm_pkg::REG_RATE_WINDOW: window_q <= cfg_data[tprm_pkg::WIN_W-1:0];
					default: ;
				endcase
			end
			if (state_q == tprm_pkg::S_CHECK && last_tick_q == '0) begin
				last_tick_q  <= now_q;
				last_bytes_q <= done_q;
			end
			if (state_q == tprm_pkg::S_RDIV && div_done) begin
				rate_q       <= (div_quo[tprm_pkg::DIV_W-1:tprm_pkg::RATE_W] != '0) ?
					tprm_pkg::RATE_MAX : div_quo[tprm_pkg::RATE_W-1:0];
				last_tick_q  <= now_q;
				last_bytes_q <= done_q;
			end
		end
	end

	// rate dividend is delta * 1000 = (delta << 10) - (delta << 4) - (delta << 3)
	// percent dividend is done * 100 = (done << 6) + (done << 5) + (done << 2)
	always_ff @(posedge clk) begin
		unique case (state_q)
			tprm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					now_q    <= s_tdata[47:0];
					base_q   <= s_tdata[94:48];
					moved_q  <= s_tdata[141:95];
					cancel_q <= s_tdata[142];
				end
			end
			tprm_pkg::S_SUM: begin
				done_q    <= {1'b0, base_q} + {1'b0, moved_q};
				elapsed_q <= now_q - last_tick_q;
			end
			tprm_pkg::S_DELTA: opnd_q <= delta_diff[tprm_pkg::DONE_W] ? '0 :
				delta_diff[tprm_pkg::DONE_W-1:0];
			tprm_pkg::S_RMUL1: prod_q <= (opnd_ext << 10) - (opnd_ext << 4);
			tprm_pkg::S_RMUL2: prod_q <= prod_q - (opnd_ext << 3);
			tprm_pkg::S_PCT: begin
				opnd_q <= done_q;
				pct_q  <= (total_q == '0) ? '0 : tprm_pkg::PCT_FULL;
			end
			tprm_pkg::S_PMUL1: prod_q <= (opnd_ext << 6) + (opnd_ext << 5);
			tprm_pkg::S_PMUL2: prod_q <= prod_q + (opnd_ext << 2);
			tprm_pkg::S_PDIV: begin
				if (div_done) begin
					pct_q <= div_quo[tprm_pkg::PCT_W-1:0];
				end
			end
			tprm_pkg::S_ETA: begin
				prod_q <= {{(tprm_pkg::DIV_W - tprm_pkg::TOTAL_W){1'b0}}, total_q - done_q};
				eta_q  <= '0;
			end
			tprm_pkg::S_EDIV: begin
				if (div_done) begin
					eta_q <= div_quo[tprm_pkg::ETA_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == tprm_pkg::S_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tprm_pkg::S_OUT && out_free) begin
			m_tdata_q <= {7'b0, cancel_q, eta_q, pct_q, rate_q, done_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("divider busy while taking an item");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[103:97] <= tprm_pkg::PCT_FULL))
		else $error("percent above full");

	a_eta_needs_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[151:104] != '0) |-> (m_tdata[96:48] != '0))
		else $error("eta without a rate");

	a_div_done_place: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == tprm_pkg::S_RDIV || state_q == tprm_pkg::S_PDIV ||
			state_q == tprm_pkg::S_EDIV))
		else $error("divider finished outside a wait state");
`endif

endmodule
